FILE: rtl/double_ended_queue_macros.svh
// Assertion macros used by the double-ended queue checker.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Condition in the same cycle implies consequence in the same cycle.
`define DQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("double_ended_queue check failed");

// Condition in one cycle implies consequence in the next cycle.
`define DQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("double_ended_queue check failed");

`endif

FILE: rtl/dq_pkg.sv
// Package with the types, codes and defaults of the double-ended queue.
package dq_pkg;

  localparam int DQ_DEPTH = 16;
  localparam int DQ_VALUE_W = 32;
  localparam int DQ_QUEUE_DEPTH = 2;

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_REAR = 3'd1;
  localparam logic [2:0] REQ_DROP_FRONT = 3'd2;
  localparam logic [2:0] REQ_DROP_REAR = 3'd3;
  localparam logic [2:0] REQ_DUMP = 3'd4;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_REAR,
    OP_DROP_FRONT,
    OP_DROP_REAR,
    OP_DUMP,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t op;
    logic signed [DQ_VALUE_W-1:0] value;
  } cmd_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

endpackage

FILE: rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit values.
// Requests enter through a two-entry command queue and are executed against a
// ring store of DEPTH entries. A push or a drop yields one result beat from the
// executor, so such requests flow at one per cycle while results are not stalled.
// A dump of n elements yields n result beats on consecutive cycles, unless the
// result output stalls, after a first read of the store through its registered
// read port; the executor holds further requests until the dump's last beat.
// An empty dump, a push on a full queue and a drop on an empty queue each give
// a single beat with the matching status and leave the contents unchanged.
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  logic [2:0]                           req_type,
  input  logic signed [dq_pkg::DQ_VALUE_W-1:0] item_value,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic signed [dq_pkg::DQ_VALUE_W-1:0] out_value,
  output logic [1:0]                           status,
  output logic                                 last,
  output logic [$clog2(DEPTH+1)-1:0]           fill_count
);

  import dq_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  dq_front u_front (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_type(req_type),
    .item_value(item_value),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd)
  );

  dq_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .out_value(out_value),
    .status(status),
    .last(last),
    .fill_count(fill_count)
  );

endmodule

FILE: rtl/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/dq_front.sv
// Request intake: decodes each request and holds it in a short command queue.
module dq_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [2:0]                    req_type,
  input  logic signed [dq_pkg::DQ_VALUE_W-1:0] item_value,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output dq_pkg::cmd_t                  cmd
);

  import dq_pkg::*;

  localparam int PTR_W = $clog2(DQ_QUEUE_DEPTH);
  localparam int USED_W = $clog2(DQ_QUEUE_DEPTH + 1);
  localparam logic [USED_W-1:0] QUEUE_FULL = USED_W'(DQ_QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DQ_QUEUE_DEPTH - 1);

  cmd_t queue_mem [DQ_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [USED_W-1:0] used;
  cmd_t decoded;
  logic push;
  logic pop;

  always_comb begin
    decoded.value = item_value;
    unique case (req_type)
      REQ_PUSH_FRONT: decoded.op = OP_PUSH_FRONT;
      REQ_PUSH_REAR: decoded.op = OP_PUSH_REAR;
      REQ_DROP_FRONT: decoded.op = OP_DROP_FRONT;
      REQ_DROP_REAR: decoded.op = OP_DROP_REAR;
      REQ_DUMP: decoded.op = OP_DUMP;
      default: decoded.op = OP_NONE;
    endcase
  end

  assign req_ready = (used != QUEUE_FULL);
  assign cmd_valid = (used != '0);
  assign cmd = queue_mem[rd_ptr];
  assign push = req_valid && req_ready;
  assign pop = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        used <= used + 1'b1;
      end else if (pop && !push) begin
        used <= used - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/dq_back.sv
// Command execution: ring store, front index, count and the result register.
module dq_back #(
  parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  output logic                                 cmd_ready,
  input  dq_pkg::cmd_t                         cmd,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic signed [dq_pkg::DQ_VALUE_W-1:0] out_value,
  output logic [1:0]                           status,
  output logic                                 last,
  output logic [$clog2(DEPTH+1)-1:0]           fill_count
);

  import dq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0] SUM_WRAP = SUM_W'(DEPTH);

  state_t state;
  state_t state_next;
  logic [IDX_W-1:0] front_index;
  logic [IDX_W-1:0] front_index_next;
  logic [CNT_W-1:0] element_count;
  logic [CNT_W-1:0] element_count_next;
  logic [IDX_W-1:0] dump_slot;
  logic [IDX_W-1:0] dump_slot_next;
  logic [CNT_W-1:0] dump_left;
  logic [CNT_W-1:0] dump_left_next;

  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] front_inc;
  logic [IDX_W-1:0] slot_inc;
  logic [SUM_W-1:0] rear_sum;
  logic [IDX_W-1:0] rear_slot;
  logic out_free;
  logic load;
  logic signed [DQ_VALUE_W-1:0] out_value_next;
  logic [1:0] status_next;
  logic last_next;

  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [DQ_VALUE_W-1:0] rd_data;

  dq_ram #(
    .WIDTH(DQ_VALUE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(cmd.value),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign front_dec = (front_index == '0) ? LAST_SLOT : front_index - 1'b1;
  assign front_inc = (front_index == LAST_SLOT) ? '0 : front_index + 1'b1;
  assign slot_inc = (dump_slot == LAST_SLOT) ? '0 : dump_slot + 1'b1;
  assign rear_sum = SUM_W'(front_index) + SUM_W'(element_count);
  assign rear_slot = (rear_sum >= SUM_WRAP) ? IDX_W'(rear_sum - SUM_WRAP) : IDX_W'(rear_sum);
  assign out_free = !res_valid || res_ready;

  always_comb begin
    state_next = state;
    front_index_next = front_index;
    element_count_next = element_count;
    dump_slot_next = dump_slot;
    dump_left_next = dump_left;
    cmd_ready = 1'b0;
    wr_en = 1'b0;
    wr_addr = rear_slot;
    rd_en = 1'b0;
    rd_addr = front_index;
    load = 1'b0;
    out_value_next = '0;
    status_next = STATUS_OK;
    last_next = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          load = 1'b1;
          unique case (cmd.op)
            OP_PUSH_FRONT: begin
              if (element_count == FULL_COUNT) begin
                status_next = STATUS_FULL;
              end else begin
                wr_en = 1'b1;
                wr_addr = front_dec;
                front_index_next = front_dec;
                element_count_next = element_count + 1'b1;
              end
            end
            OP_PUSH_REAR: begin
              if (element_count == FULL_COUNT) begin
                status_next = STATUS_FULL;
              end else begin
                wr_en = 1'b1;
                element_count_next = element_count + 1'b1;
              end
            end
            OP_DROP_FRONT: begin
              if (element_count == '0) begin
                status_next = STATUS_EMPTY;
              end else begin
                front_index_next = front_inc;
                element_count_next = element_count - 1'b1;
              end
            end
            OP_DROP_REAR: begin
              if (element_count == '0) begin
                status_next = STATUS_EMPTY;
              end else begin
                element_count_next = element_count - 1'b1;
              end
            end
            OP_DUMP: begin
              if (element_count == '0) begin
                status_next = STATUS_EMPTY;
              end else begin
                load = 1'b0;
                rd_en = 1'b1;
                dump_slot_next = front_index;
                dump_left_next = element_count;
                state_next = S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          load = 1'b1;
          out_value_next = rd_data;
          last_next = (dump_left == CNT_W'(1));
          rd_en = !last_next;
          rd_addr = slot_inc;
          dump_slot_next = slot_inc;
          dump_left_next = dump_left - 1'b1;
          if (last_next) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front_index <= '0;
      element_count <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      front_index <= front_index_next;
      element_count <= element_count_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dump_slot <= dump_slot_next;
    dump_left <= dump_left_next;
    if (load) begin
      out_value <= out_value_next;
      status <= status_next;
      last <= last_next;
      fill_count <= element_count_next;
    end
  end

endmodule

FILE: rtl/dq_checker.sv
// Port-level checks of the double-ended queue and their bind to the top level.
`include "double_ended_queue_macros.svh"

module dq_checker #(
  parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 res_valid,
  input logic                                 res_ready,
  input logic signed [dq_pkg::DQ_VALUE_W-1:0] out_value,
  input logic [1:0]                           status,
  input logic                                 last,
  input logic [$clog2(DEPTH+1)-1:0]           fill_count
);

  import dq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  logic [DQ_VALUE_W+CNT_W+2:0] res_beat;
  logic empty_beat;

  assign res_beat = {out_value, status, last, fill_count};
  assign empty_beat = res_valid && (status == STATUS_EMPTY);

  `DQ_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_beat))
  `DQ_ASSERT_SAME(a_fill_bound, res_valid, fill_count <= FULL_COUNT)
  `DQ_ASSERT_SAME(a_dump_beat_ok, res_valid && !last, status == STATUS_OK)
  `DQ_ASSERT_SAME(a_empty_beat, empty_beat, fill_count == '0 && out_value == '0 && last)

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);
